[rtl/core/ffp_pkg.sv]
`default_nettype none

package ffp_pkg;

  // Field widths of the transactions
  localparam int PLACE_W = 7;
  localparam int BEST_W  = 7;

  // Operation codes
  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_UNDO = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [PLACE_W-1:0] place;
  } in_t;

  typedef struct packed {
    logic [BEST_W-1:0] best_place;
    logic              answer_valid;
    logic              rejected;
  } out_t;

endpackage

`default_nettype wire

[rtl/core/farthest_free_place_picker.sv]
// Sequence: a take runs S_IDLE, S_OCC_RD, S_SCAN, S_DONE; an undo adds S_POP_RD
//   before S_OCC_RD; a rejected item goes from S_IDLE straight to S_SCAN.
// Throughput: one transaction at a time; the next is taken only once S_DONE has loaded
//   the result and the sequencer is back in S_IDLE; the scan reads one place per cycle.
// Reset: synchronous active-low rst_n; afterwards a clearing pass zeroes the
//   occupancy RAM with in_stall held high.
`default_nettype none

module farthest_free_place_picker #(
  parameter int NUM_PLACES  = 100,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ffp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ffp_pkg::out_t      out_data
);

  localparam int PW  = $clog2(NUM_PLACES + 1);       // place number width
  localparam int OAW = $clog2(NUM_PLACES);           // occupancy RAM address
  localparam int CW  = $clog2(STACK_DEPTH + 1);      // count / fill width
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int XW  = (PW > ffp_pkg::PLACE_W) ? PW : ffp_pkg::PLACE_W;
  localparam int BW  = ffp_pkg::BEST_W;

  typedef enum logic [2:0] {
    S_CLEAR,   // post-reset sweep of the occupancy RAM
    S_IDLE,    // ready for a transaction
    S_POP_RD,  // undo: stack top arrives
    S_OCC_RD,  // count arrives, write back +1 / -1
    S_SCAN,    // stream all counts through the gap tracker
    S_DONE     // load the result register
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [OAW-1:0] clr_r, clr_nxt;
  logic [OAW-1:0] op_addr_r, op_addr_nxt;
  logic           dec_r, dec_nxt;
  logic           rej_r, rej_nxt;
  logic [PW-1:0]  scan_r, scan_nxt;
  logic           smp_vld_r, smp_vld_nxt;
  logic [PW-1:0]  smp_place_r, smp_place_nxt;
  logic           out_valid_r, out_valid_nxt;
  ffp_pkg::out_t  out_data_r, out_data_nxt;

  // Occupancy RAM ports
  logic           occ_we;
  logic [OAW-1:0] occ_waddr, occ_raddr;
  logic [CW-1:0]  occ_wdata, occ_rdata;

  // Undo stack RAM ports
  logic           stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [ffp_pkg::PLACE_W-1:0] stk_rdata;

  logic           accept;
  logic           place_ok, stack_full;
  logic [OAW-1:0] in_addr, top_addr;
  logic [PW-1:0]  scan_best;
  logic           scan_clr;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign place_ok   = (in_data.place != '0) && (XW'(in_data.place) <= XW'(NUM_PLACES));
  assign stack_full = (fill_r == CW'(STACK_DEPTH));
  assign in_addr    = OAW'(XW'(in_data.place) - XW'(1));
  assign top_addr   = OAW'(XW'(stk_rdata) - XW'(1));

  // Push writes at the current fill; pop reads one below it
  assign stk_waddr  = SAW'(fill_r);
  assign stk_raddr  = SAW'(fill_r - CW'(1));
  assign stk_we     = accept && (in_data.operation == ffp_pkg::OP_TAKE) &&
                      place_ok && !stack_full;

  assign scan_clr   = (state_r != S_SCAN) && (state_r != S_DONE);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    clr_nxt       = clr_r;
    op_addr_nxt   = op_addr_r;
    dec_nxt       = dec_r;
    rej_nxt       = rej_r;
    scan_nxt      = '0;
    smp_vld_nxt   = 1'b0;
    smp_place_nxt = smp_place_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    occ_we        = 1'b0;
    occ_waddr     = op_addr_r;
    occ_wdata     = '0;
    occ_raddr     = '0;

    case (state_r)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_r;
        clr_nxt   = clr_r + OAW'(1);
        if (clr_r == OAW'(NUM_PLACES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        occ_raddr = in_addr;
        if (accept) begin
          rej_nxt = 1'b0;
          if (in_data.operation == ffp_pkg::OP_TAKE) begin
            if (!place_ok || stack_full) begin
              rej_nxt   = 1'b1;
              state_nxt = S_SCAN;
            end else begin
              fill_nxt    = fill_r + CW'(1);
              op_addr_nxt = in_addr;
              dec_nxt     = 1'b0;
              state_nxt   = S_OCC_RD;
            end
          end else begin
            if (fill_r == '0) begin
              rej_nxt   = 1'b1;
              state_nxt = S_SCAN;
            end else begin
              fill_nxt  = fill_r - CW'(1);
              dec_nxt   = 1'b1;
              state_nxt = S_POP_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        occ_raddr   = top_addr;
        op_addr_nxt = top_addr;
        state_nxt   = S_OCC_RD;
      end
      S_OCC_RD: begin
        // counts never go below zero
        occ_waddr = op_addr_r;
        if (dec_r) begin
          occ_we    = (occ_rdata != '0);
          occ_wdata = occ_rdata - CW'(1);
        end else begin
          occ_we    = 1'b1;
          occ_wdata = occ_rdata + CW'(1);
        end
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        occ_raddr = OAW'(scan_r);
        if (scan_r != PW'(NUM_PLACES)) begin
          scan_nxt      = scan_r + PW'(1);
          smp_vld_nxt   = 1'b1;
          smp_place_nxt = scan_r + PW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.answer_valid = (fill_r != '0);
          out_data_nxt.rejected     = rej_r;
          out_data_nxt.best_place   = (fill_r != '0) ? BW'(scan_best) : '0;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      fill_r      <= '0;
      clr_r       <= '0;
      scan_r      <= '0;
      smp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rej_r       <= 1'b0;
      dec_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      clr_r       <= clr_nxt;
      scan_r      <= scan_nxt;
      smp_vld_r   <= smp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      rej_r       <= rej_nxt;
      dec_r       <= dec_nxt;
      op_addr_r   <= op_addr_nxt;
      smp_place_r <= smp_place_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  ffp_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_PLACES)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  ffp_ram #(
    .WIDTH (ffp_pkg::PLACE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (in_data.place),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ffp_scan #(
    .NUM_PLACES (NUM_PLACES)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (scan_clr),
    .smp_vld  (smp_vld_r),
    .occupied (occ_rdata != '0),
    .place    (smp_place_r),
    .single   (fill_r == CW'(1)),
    .best     (scan_best)
  );

  // Stack fill stays within its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  // Accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("transaction accepted but sequencer stayed idle");

  // Empty set reports no place
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.answer_valid |-> out_data_r.best_place == '0)
    else $error("place reported on empty set");

  // Occupancy RAM is written only by the sweep or the count update
  a_occ_write: assert property (@(posedge clk) disable iff (!rst_n)
    occ_we |-> state_r == S_CLEAR || state_r == S_OCC_RD)
    else $error("stray occupancy write");

  // Undo on empty stack leaves fill at zero
  a_undo_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.operation == ffp_pkg::OP_UNDO && fill_r == '0 |=> fill_r == '0)
    else $error("fill moved on rejected undo");

endmodule

`default_nettype wire

[rtl/core/ffp_ram.sv]
`default_nettype none

module ffp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/ffp_scan.sv]
`default_nettype none

// Gap tracker: consumes one place per cycle in ascending order, then picks.
module ffp_scan #(
  parameter int NUM_PLACES = 100
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              clr,
  input  wire logic                              smp_vld,
  input  wire logic                              occupied,
  input  wire logic [$clog2(NUM_PLACES+1)-1:0]   place,
  input  wire logic                              single,
  output logic      [$clog2(NUM_PLACES+1)-1:0]   best
);

  localparam int PW = $clog2(NUM_PLACES + 1);

  logic [PW-1:0] first_r, prev_r, gap_r, gplace_r;
  logic [PW-1:0] gap_dist;
  logic [PW-1:0] left_dist, right_dist, interior;

  assign gap_dist = (place - prev_r) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      first_r  <= '0;
      prev_r   <= '0;
      gap_r    <= '0;
      gplace_r <= '0;
    end else if (smp_vld && occupied) begin
      if (first_r == '0) begin
        first_r <= place;
      end else if (gap_dist > gap_r) begin
        gap_r    <= gap_dist;
        gplace_r <= place - gap_dist;
      end
      prev_r <= place;
    end
  end

  // End distances against the best halved gap; ties fall to the interior
  assign left_dist  = first_r - PW'(1);
  assign right_dist = PW'(NUM_PLACES) - prev_r;
  assign interior   = single ? first_r : gplace_r;

  always_comb begin
    if (left_dist > gap_r && left_dist > right_dist) begin
      best = PW'(1);
    end else if (right_dist > gap_r && right_dist > left_dist) begin
      best = PW'(NUM_PLACES);
    end else begin
      best = interior;
    end
  end

endmodule

`default_nettype wire

[dv/farthest_free_place_picker_tb.sv]
`timescale 1ns / 100ps

module farthest_free_place_picker_tb;

  localparam int PLACES      = 100;
  localparam int STACK_SLOTS = 256;
  localparam int SCRIPT_LEN  = 22;
  // Longest wait for one transaction: an undo, which adds S_POP_RD to a take's path.
  localparam int SETTLE_CYCLES = 2 * PLACES + 16;

  // One row of the opening script. When 'known' is set, the expected answer
  // is typed in by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic                        operation;
    logic [ffp_pkg::PLACE_W-1:0] place;
    logic                        known;
    logic [ffp_pkg::BEST_W-1:0]  best;
    logic                        answer;
    logic                        refused;
  } script_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ffp_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ffp_pkg::out_t out_data;

  // Predictor state: how often each place is taken, and the undo history.
  logic [8:0]                  seat_count [1:PLACES];
  logic [ffp_pkg::PLACE_W-1:0] take_stack [0:STACK_SLOTS-1];
  int                          take_depth;

  ffp_pkg::out_t expected_picks [$];
  int   failures = 0;
  int   results_checked = 0;

  // Idle odds per cycle, in percent, for each side. Changed per phase.
  int send_idle_pct = 36;
  int recv_idle_pct = 68;

  // Long receiver hold-off, counted in the receiver's own process.
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Opening script: field extremes, both operations, refusals of bad places and of an empty
  // undo, and the corner cases of the pick (single take, both ends, no usable gap).
  script_row_t opening_script [SCRIPT_LEN] = '{
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b1, 7'd0,   1'b0, 1'b1},  // undo on empty stack
    '{ffp_pkg::OP_TAKE, 7'd0,   1'b1, 7'd0,   1'b0, 1'b1},  // place below range
    '{ffp_pkg::OP_TAKE, 7'd127, 1'b1, 7'd0,   1'b0, 1'b1},  // all place bits set
    '{ffp_pkg::OP_TAKE, 7'd101, 1'b1, 7'd0,   1'b0, 1'b1},  // one past the last place
    '{ffp_pkg::OP_TAKE, 7'd1,   1'b1, 7'd100, 1'b1, 1'b0},  // left end taken: right wins
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b1, 7'd0,   1'b0, 1'b0},  // back to empty
    '{ffp_pkg::OP_TAKE, 7'd100, 1'b1, 7'd1,   1'b1, 1'b0},  // right end taken: left wins
    '{ffp_pkg::OP_TAKE, 7'd1,   1'b1, 7'd51,  1'b1, 1'b0},  // both ends: middle of the row
    '{ffp_pkg::OP_TAKE, 7'd50,  1'b0, 7'd0,   1'b0, 1'b0},  // second gap is wider
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b1, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_TAKE, 7'd50,  1'b0, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_TAKE, 7'd51,  1'b1, 7'd0,   1'b1, 1'b0},  // ends tie, no gap: no place
    '{ffp_pkg::OP_TAKE, 7'd51,  1'b0, 7'd0,   1'b0, 1'b0},  // repeated place
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b1, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_TAKE, 7'd64,  1'b0, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_TAKE, 7'd63,  1'b0, 7'd0,   1'b0, 1'b0},
    '{ffp_pkg::OP_UNDO, 7'd127, 1'b0, 7'd0,   1'b0, 1'b0},  // place field ignored on undo
    '{ffp_pkg::OP_UNDO, 7'd0,   1'b1, 7'd0,   1'b0, 1'b0}
  };

  farthest_free_place_picker #(
    .NUM_PLACES (PLACES),
    .STACK_DEPTH(STACK_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one accepted transaction to the predictor state and returns the
  // answer the block must give afterwards.
  function automatic ffp_pkg::out_t apply_and_pick(input ffp_pkg::in_t req);
    ffp_pkg::out_t               res;
    logic [ffp_pkg::PLACE_W-1:0] top;
    int                          p, first_p, last_p, prev_p, gap_d, gap_at, d, left_d, right_d;
    res = '0;
    if (req.operation == ffp_pkg::OP_TAKE) begin
      if (req.place < 1 || req.place > PLACES || take_depth >= STACK_SLOTS) begin
        res.rejected = 1'b1;
      end else begin
        take_stack[take_depth] = req.place;
        take_depth++;
        seat_count[req.place] = seat_count[req.place] + 9'd1;
      end
    end else if (take_depth == 0) begin
      res.rejected = 1'b1;
    end else begin
      take_depth--;
      top = take_stack[take_depth];
      if (seat_count[top] != 0) seat_count[top] = seat_count[top] - 9'd1;
    end

    res.answer_valid = (take_depth != 0);
    if (take_depth != 0) begin
      first_p = 0;
      last_p  = 0;
      prev_p  = 0;
      gap_d   = 0;
      gap_at  = 0;
      for (p = 1; p <= PLACES; p++) begin
        if (seat_count[p] != 0) begin
          if (first_p == 0) begin
            first_p = p;
          end else begin
            // Only a strictly wider gap displaces an earlier one.
            d = (p - prev_p) / 2;
            if (d > gap_d) begin
              gap_d  = d;
              gap_at = p - d;
            end
          end
          prev_p = p;
          last_p = p;
        end
      end
      left_d  = first_p - 1;
      right_d = PLACES - last_p;
      if (left_d > gap_d && left_d > right_d) begin
        res.best_place = ffp_pkg::BEST_W'(1);
      end else if (right_d > gap_d && right_d > left_d) begin
        res.best_place = ffp_pkg::BEST_W'(PLACES);
      end else begin
        // A lone take stands in for the interior pick; otherwise the gap
        // midpoint, which stays 0 when no gap has positive width.
        res.best_place = ffp_pkg::BEST_W'((take_depth > 1) ? gap_at : first_p);
      end
    end
    return res;
  endfunction

  // Offers one transaction and holds it until accepted, then records the
  // expected answer and may idle the sender, with the odds in send_idle_pct.
  task automatic send_request(input ffp_pkg::in_t req, input bit known,
                              input ffp_pkg::out_t typed);
    ffp_pkg::out_t predicted;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = apply_and_pick(req);
    expected_picks.push_back(known ? typed : predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Sender stops offering until every expected answer is back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_picks.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed takes and undos; takes cluster around a moving anchor
  // so repeats and adjacent places (zero-width gaps) show up often. The undo
  // odds rise with the stack depth to keep it from running away.
  task automatic run_random_phase(input int count);
    ffp_pkg::in_t req;
    int  roll, undo_pct, anchor;
    anchor = $urandom_range(1, PLACES - 3);
    repeat (count) begin
      roll     = $urandom_range(99);
      undo_pct = (take_depth > 40) ? 55 : 30;
      req.place = ffp_pkg::PLACE_W'($urandom_range(127));
      if (roll < 6) begin
        req.operation = ffp_pkg::OP_TAKE;
        req.place = $urandom_range(1) ? '0
                                      : ffp_pkg::PLACE_W'($urandom_range(PLACES + 1, 127));
      end else if (roll < 6 + undo_pct) begin
        req.operation = ffp_pkg::OP_UNDO;
      end else begin
        req.operation = ffp_pkg::OP_TAKE;
        if ($urandom_range(9) == 0) anchor = $urandom_range(1, PLACES - 3);
        req.place = $urandom_range(1) ? ffp_pkg::PLACE_W'($urandom_range(1, PLACES))
                                      : ffp_pkg::PLACE_W'(anchor + $urandom_range(3));
      end
      send_request(req, 1'b0, '0);
    end
  endtask

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      failures++;
    end
  endtask

  task automatic check_pick(input ffp_pkg::out_t got);
    ffp_pkg::out_t want;
    if (expected_picks.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, actual %0d/%0b/%0b",
               $time, got.best_place, got.answer_valid, got.rejected);
      failures++;
    end else begin
      want = expected_picks.pop_front();
      compare_field("best_place", 8'(want.best_place), 8'(got.best_place));
      compare_field("answer_valid", 8'(want.answer_valid), 8'(got.answer_valid));
      compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
    end
    results_checked++;
  endtask

  // Result side: check every accepted transaction against the oldest
  // expectation, then pick next cycle's stall. Once, after 150 results, the
  // receiver holds off, counted down in hold_left, so the block backs up into in_stall.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) check_pick(out_data);
    if (!hold_done && results_checked == 150) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    ffp_pkg::in_t  req;
    ffp_pkg::out_t typed;
    int            p;

    take_depth = 0;
    for (p = 1; p <= PLACES; p++) seat_count[p] = '0;

    // Hold reset, then release it; the block then clears its occupancy store with
    // in_stall high, which the handshake absorbs.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender idles often, receiver idles more.
    send_idle_pct = 36;
    recv_idle_pct = 68;
    foreach (opening_script[i]) begin
      req.operation = opening_script[i].operation;
      req.place     = opening_script[i].place;
      typed = {opening_script[i].best, opening_script[i].answer, opening_script[i].refused};
      send_request(req, opening_script[i].known, typed);
    end
    run_random_phase(460);
    wait_for_drain();

    // Phase 2: the other way round.
    send_idle_pct = 68;
    recv_idle_pct = 36;
    run_random_phase(460);
    wait_for_drain();

    // Phase 3: no idling. Fill the whole row (no free place left), push the
    // stack to full and beyond, then undo everything and past empty.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    req.operation = ffp_pkg::OP_TAKE;
    for (p = 1; p <= PLACES; p++) begin
      req.place = ffp_pkg::PLACE_W'(p);
      send_request(req, 1'b0, '0);
    end
    repeat (STACK_SLOTS - PLACES + 4) begin
      req.place = ffp_pkg::PLACE_W'($urandom_range(1, PLACES));
      send_request(req, 1'b0, '0);
    end
    req.operation = ffp_pkg::OP_UNDO;
    repeat (STACK_SLOTS + 2) begin
      req.place = ffp_pkg::PLACE_W'($urandom_range(127));
      send_request(req, 1'b0, '0);
    end

    // Let any stray result show up before the verdict.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
